// ===== hdl/m3i_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package m3i_pkg;

    localparam int DW            = 32;   // element and result width
    localparam int NEL           = 9;    // elements per matrix
    localparam int CW            = 64;   // exact cofactor width
    localparam int DETW          = 98;   // exact determinant width
    localparam int QBITS         = 32;   // quotient bits kept per lane
    localparam int NTERM         = 3;    // first-row expansion terms
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [DW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] SAT_MIN = 32'h8000_0000;

    // cofactor k = m[A1]*m[A2] - m[B1]*m[B2]
    localparam logic [3:0] CF_A1 [NEL] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] CF_A2 [NEL] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] CF_B1 [NEL] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] CF_B2 [NEL] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic [DW-1:0] det_value;
        logic          singular;
    } side_t;

    typedef struct packed {
        logic [QBITS-1:0] quo;
        logic             ovf;
        logic             neg;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== hdl/matrix3_inverse.sv =====
// An accepted input word passes the front end, the divider lanes and the output register before out_valid rises.
// Throughput: one matrix per cycle while the output is not stalled; every stage of the cofactor, determinant
// and nine divider lanes is pipelined, so items follow back to back.
// A stalled full output register holds the pipe once its last stage is full too.
// Reset (rst_n, async, active low) clears only the valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [m3i_pkg::DW-1:0]  a00,
    input  logic signed [m3i_pkg::DW-1:0]  a01,
    input  logic signed [m3i_pkg::DW-1:0]  a02,
    input  logic signed [m3i_pkg::DW-1:0]  a10,
    input  logic signed [m3i_pkg::DW-1:0]  a11,
    input  logic signed [m3i_pkg::DW-1:0]  a12,
    input  logic signed [m3i_pkg::DW-1:0]  a20,
    input  logic signed [m3i_pkg::DW-1:0]  a21,
    input  logic signed [m3i_pkg::DW-1:0]  a22,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [m3i_pkg::DW-1:0]  b00,
    output logic signed [m3i_pkg::DW-1:0]  b01,
    output logic signed [m3i_pkg::DW-1:0]  b02,
    output logic signed [m3i_pkg::DW-1:0]  b10,
    output logic signed [m3i_pkg::DW-1:0]  b11,
    output logic signed [m3i_pkg::DW-1:0]  b12,
    output logic signed [m3i_pkg::DW-1:0]  b20,
    output logic signed [m3i_pkg::DW-1:0]  b21,
    output logic signed [m3i_pkg::DW-1:0]  b22,
    output logic signed [m3i_pkg::DW-1:0]  det_value,
    output logic                           singular
);
    import m3i_pkg::*;

    localparam int NUMW    = CW + 2 * FRAC_BITS;
    localparam int FRONT_N = 6;
    localparam int PIPE    = FRONT_N + 1 + QBITS;

    logic signed [DW-1:0] m_in [NEL];
    logic [NUMW-1:0]      num  [NEL];
    logic                 neg  [NEL];
    logic [DETW-1:0]      mag;
    side_t                side_front;
    side_t                side_reg [QBITS+1];
    lane_res_t            res  [NEL];
    logic [DW-1:0]        b    [NEL];
    logic [PIPE-1:0]      vld_reg;
    logic [PIPE-1:0]      vld_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 en;
    logic                 out_en;

    assign m_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

    // pipe moves unless its last word has nowhere to go
    assign out_en   = !out_valid_reg || !out_stall;
    assign en       = out_en || !vld_reg[PIPE-1];
    assign in_stall = !en;

    always_comb
    begin
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg;
        if (en)
            vld_next = {vld_reg[PIPE-2:0], in_valid};
        if (out_en)
            out_valid_next = vld_reg[PIPE-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk  (clk),
        .en   (en),
        .m_in (m_in),
        .num  (num),
        .neg  (neg),
        .mag  (mag),
        .side (side_front)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_front;
            for (int i = 1; i <= QBITS; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    genvar k;
    generate
        for (k = 0; k < NEL; k++) begin : g_lane
            m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .clk (clk),
                .en  (en),
                .num (num[k]),
                .den (mag),
                .neg (neg[k]),
                .res (res[k])
            );
        end
    endgenerate

    m3i_merge u_merge (
        .clk       (clk),
        .load      (out_en),
        .res       (res),
        .side      (side_reg[QBITS]),
        .b         (b),
        .det_value (det_value),
        .singular  (singular)
    );

    assign out_valid = out_valid_reg;
    assign b00 = b[0];
    assign b01 = b[1];
    assign b02 = b[2];
    assign b10 = b[3];
    assign b11 = b[4];
    assign b12 = b[5];
    assign b20 = b[6];
    assign b21 = b[7];
    assign b22 = b[8];

`ifndef NO_ASSERTIONS
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (b00 == 0 && b01 == 0 && b02 == 0 && b10 == 0 &&
            b11 == 0 && b12 == 0 && b20 == 0 && b21 == 0 && b22 == 0 && det_value == 0))
        else $error("singular word with nonzero result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output");

    a_idle_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted word lost at pipe entry");
`endif

endmodule

`default_nettype wire

// ===== hdl/m3i_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_front #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [m3i_pkg::DW-1:0]            m_in [m3i_pkg::NEL],
    output logic [m3i_pkg::CW+2*FRAC_BITS-1:0]       num  [m3i_pkg::NEL],
    output logic                                     neg  [m3i_pkg::NEL],
    output logic [m3i_pkg::DETW-1:0]                 mag,
    output m3i_pkg::side_t                           side
);
    import m3i_pkg::*;

    localparam int NUMW = CW + 2 * FRAC_BITS;

    logic signed [CW-1:0]   pa_reg [NEL];
    logic signed [CW-1:0]   pb_reg [NEL];
    logic signed [CW-1:0]   c_reg  [NEL];
    logic signed [CW-1:0]   c1_reg [NEL];
    logic signed [CW-1:0]   c2_reg [NEL];
    logic signed [CW-1:0]   c3_reg [NEL];
    logic signed [DW-1:0]   mp_reg [NTERM];
    logic signed [DW-1:0]   mc_reg [NTERM];
    logic signed [CW:0]     lo_reg [NTERM];
    logic signed [CW-1:0]   hi_reg [NTERM];
    logic [DW+CW-1:0]       term_reg [NTERM];
    logic signed [DETW-1:0] det_reg;
    logic [NUMW-1:0]        num_reg [NEL];
    logic                   neg_reg [NEL];
    logic [DETW-1:0]        mag_reg;
    side_t                  side_reg;
    side_t                  side_next;
    logic signed [DETW-1:0] det_sh;

    genvar k;
    generate
        for (k = 0; k < NEL; k++) begin : g_cof
            logic [CW-1:0] cabs;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pa_reg[k] <= m_in[CF_A1[k]] * m_in[CF_A2[k]];
                    pb_reg[k] <= m_in[CF_B1[k]] * m_in[CF_B2[k]];
                    c_reg[k]  <= pa_reg[k] - pb_reg[k];
                    c1_reg[k] <= c_reg[k];
                    c2_reg[k] <= c1_reg[k];
                    c3_reg[k] <= c2_reg[k];
                end
            end
            assign cabs = c3_reg[k][CW-1] ? CW'(-c3_reg[k]) : c3_reg[k];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k] <= {cabs, {(2 * FRAC_BITS){1'b0}}};
                    neg_reg[k] <= c3_reg[k][CW-1] ^ det_reg[DETW-1];
                end
            end
            assign num[k] = num_reg[k];
            assign neg[k] = neg_reg[k];
        end

        // det = m0*c0 + m1*c3 + m2*c6, each 32x64 product split in two halves
        for (k = 0; k < NTERM; k++) begin : g_term
            logic signed [DW:0]   clo;
            logic signed [DW-1:0] chi;
            assign clo = {1'b0, c_reg[3*k][DW-1:0]};
            assign chi = c_reg[3*k][CW-1:DW];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    mp_reg[k]   <= m_in[k];
                    mc_reg[k]   <= mp_reg[k];
                    lo_reg[k]   <= mc_reg[k] * clo;
                    hi_reg[k]   <= mc_reg[k] * chi;
                    term_reg[k] <= {hi_reg[k], {DW{1'b0}}}
                                 + {{(DW-1){lo_reg[k][CW]}}, lo_reg[k]};
                end
            end
        end
    endgenerate

    always_comb
    begin
        det_sh = det_reg >>> (2 * FRAC_BITS);
        side_next.singular = (det_reg == '0);
        if (&det_sh[DETW-1:DW-1] || ~|det_sh[DETW-1:DW-1])
            side_next.det_value = det_sh[DW-1:0];
        else if (det_sh[DETW-1])
            side_next.det_value = SAT_MIN;
        else
            side_next.det_value = SAT_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg  <= {{(DETW-DW-CW){term_reg[0][DW+CW-1]}}, term_reg[0]}
                      + {{(DETW-DW-CW){term_reg[1][DW+CW-1]}}, term_reg[1]}
                      + {{(DETW-DW-CW){term_reg[2][DW+CW-1]}}, term_reg[2]};
            mag_reg  <= det_reg[DETW-1] ? DETW'(-det_reg) : det_reg;
            side_reg <= side_next;
        end
    end

    assign mag  = mag_reg;
    assign side = side_reg;

endmodule

`default_nettype wire

// ===== hdl/m3i_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_div_lane #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [m3i_pkg::CW+2*FRAC_BITS-1:0]  num,
    input  logic [m3i_pkg::DETW-1:0]            den,
    input  logic                                neg,
    output m3i_pkg::lane_res_t                  res
);
    import m3i_pkg::*;

    localparam int NUMW = CW + 2 * FRAC_BITS;
    localparam int WW   = (NUMW > DETW + QBITS) ? NUMW : DETW + QBITS;

    logic [WW-1:0]    rem_reg [QBITS+1];
    logic [DETW-1:0]  den_reg [QBITS+1];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic             ovf_reg [QBITS+1];
    logic             neg_reg [QBITS+1];

    // quotient overflows the kept bits when num >= den * 2^QBITS
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= WW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= WW'(num) >= (WW'(den) << QBITS);
            neg_reg[0] <= neg;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QBITS; j++) begin : g_step
            logic [WW-1:0] dsh;
            logic [WW:0]   diff;
            assign dsh  = WW'(den_reg[j]) << (QBITS - 1 - j);
            assign diff = {1'b0, rem_reg[j]} - {1'b0, dsh};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= diff[WW] ? rem_reg[j] : diff[WW-1:0];
                    q_reg[j+1]   <= q_reg[j] | (diff[WW] ? '0 : (QBITS'(1) << (QBITS - 1 - j)));
                    den_reg[j+1] <= den_reg[j];
                    ovf_reg[j+1] <= ovf_reg[j];
                    neg_reg[j+1] <= neg_reg[j];
                end
            end
        end
    endgenerate

    assign res.quo = q_reg[QBITS];
    assign res.ovf = ovf_reg[QBITS];
    assign res.neg = neg_reg[QBITS];

endmodule

`default_nettype wire

// ===== hdl/m3i_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_merge (
    input  logic                          clk,
    input  logic                          load,
    input  m3i_pkg::lane_res_t            res  [m3i_pkg::NEL],
    input  m3i_pkg::side_t                side,
    output logic [m3i_pkg::DW-1:0]        b    [m3i_pkg::NEL],
    output logic [m3i_pkg::DW-1:0]        det_value,
    output logic                          singular
);
    import m3i_pkg::*;

    logic [DW-1:0] b_reg  [NEL];
    logic [DW-1:0] b_next [NEL];
    side_t         side_reg;

    always_comb
    begin
        for (int k = 0; k < NEL; k++)
        begin
            if (side.singular)
                b_next[k] = '0;
            else if (res[k].neg)
                b_next[k] = (res[k].ovf || res[k].quo > SAT_MIN) ? SAT_MIN : DW'(-res[k].quo);
            else
                b_next[k] = (res[k].ovf || res[k].quo[QBITS-1]) ? SAT_MAX : res[k].quo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_reg    <= b_next;
            side_reg <= side;
        end
    end

    assign b         = b_reg;
    assign det_value = side_reg.singular ? '0 : side_reg.det_value;
    assign singular  = side_reg.singular;

endmodule

`default_nettype wire
